>>> src/lmsb_pkg.sv
package lmsb_pkg;

    // Operation codes carried in the command transaction.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FILL  = 2'd1,
        OP_SCAN  = 2'd2,
        OP_BLINK = 2'd3
    } op_t;

    // Lamp modes.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_SLOW = 2'd2;
    localparam logic [1:0] MODE_FAST = 2'd3;

    localparam int CMD_W    = 8;
    localparam int MODE_W   = 2;
    localparam int DATA_W   = 4;
    localparam int STROBE_W = 4;

    // Command transaction payload.
    typedef struct packed {
        op_t                 operation;
        logic [CMD_W-1:0]    command_byte;
        logic [MODE_W-1:0]   fill_mode;
    } cmd_t;

    // Result transaction payload.
    typedef struct packed {
        logic [DATA_W-1:0]   lamp_data;
        logic [STROBE_W-1:0] strobe_enable;
        logic                lit;
    } res_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic do_write;
        logic do_fill;
        logic do_scan;
        logic do_blink;
        logic load_out;
    } dp_ctrl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

>>> src/lmsb_ctrl.sv
module lmsb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  lmsb_pkg::op_t      operation,
    output logic               cmd_stall,
    input  lmsb_pkg::dp_status_t status,
    output lmsb_pkg::dp_ctrl_t ctrl
);
    import lmsb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = cmd_valid && (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a scan passes through the lookup state for the table read.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_SCAN)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: decode the accepted operation and time the result load.
    always_comb
    begin
        cmd_stall     = 1'b1;
        ctrl.do_write = 1'b0;
        ctrl.do_fill  = 1'b0;
        ctrl.do_scan  = 1'b0;
        ctrl.do_blink = 1'b0;
        ctrl.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall     = 1'b0;
                ctrl.do_write = accept && (operation == OP_WRITE);
                ctrl.do_fill  = accept && (operation == OP_FILL);
                ctrl.do_scan  = accept && (operation == OP_SCAN);
                ctrl.do_blink = accept && (operation == OP_BLINK);
            end
            ST_LOOKUP:
            begin
                ctrl.load_out = status.out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> src/lmsb_datapath.sv
module lmsb_datapath #(
    parameter int LAMP_COUNT      = 64,
    parameter int GROUP_COUNT     = 4,
    parameter int LAMPS_PER_GROUP = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lmsb_pkg::dp_ctrl_t   ctrl,
    output lmsb_pkg::dp_status_t status,
    input  lmsb_pkg::cmd_t       cmd_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output lmsb_pkg::res_t       res_data
);
    import lmsb_pkg::*;

    localparam int GRP_W    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int LAMP_W   = $clog2(LAMPS_PER_GROUP);
    localparam int ADDR_W   = $clog2(LAMP_COUNT);
    localparam int SPAN     = GROUP_COUNT * LAMPS_PER_GROUP;
    localparam int IDX_W    = (($clog2(SPAN) > ADDR_W) ? $clog2(SPAN) : ADDR_W) + 1;
    localparam int WIDX_W   = CMD_W - MODE_W;
    localparam int WCMP_W   = ((ADDR_W > WIDX_W) ? ADDR_W : WIDX_W) + 1;

    // Lamp table with per-entry valid bits; an unwritten entry reads as the fill mode.
    logic [MODE_W-1:0] lamp_mem [LAMP_COUNT];
    logic [LAMP_COUNT-1:0] entry_valid_reg;
    logic [MODE_W-1:0]     fill_mode_reg;

    logic [LAMP_W-1:0]   scan_lamp_reg;
    logic [GRP_W-1:0]    scan_group_reg;
    logic [1:0]          blink_phase_reg;
    logic                slow_on_reg;
    logic                fast_on_reg;

    logic [MODE_W-1:0]   rd_mode_reg;
    logic                rd_hit_reg;
    logic                rd_in_range_reg;
    logic [DATA_W-1:0]   pend_data_reg;
    logic [STROBE_W-1:0] pend_strobe_reg;

    res_t                out_data_reg;
    logic                out_valid_reg;

    logic [WCMP_W-1:0]   wr_idx;
    logic                wr_in_range;
    logic [ADDR_W-1:0]   wr_addr;
    logic [IDX_W-1:0]    scan_idx;
    logic                scan_in_range;
    logic [ADDR_W-1:0]   rd_addr;
    logic [STROBE_W:0]   grp_ext;
    logic [STROBE_W-1:0] strobe;
    logic [GRP_W:0]      grp_inc;
    logic [LAMP_W:0]     lamp_inc;
    logic [MODE_W-1:0]   cur_mode;
    logic                lit;

    // Write address decode.
    assign wr_idx      = WCMP_W'(cmd_data.command_byte[CMD_W-1:MODE_W]);
    assign wr_in_range = wr_idx < WCMP_W'(LAMP_COUNT);
    assign wr_addr     = wr_idx[ADDR_W-1:0];

    // Visited lamp index and group strobe.
    assign scan_idx      = IDX_W'(scan_group_reg) * IDX_W'(LAMPS_PER_GROUP)
                         + IDX_W'(scan_lamp_reg);
    assign scan_in_range = scan_idx < IDX_W'(LAMP_COUNT);
    assign rd_addr       = scan_idx[ADDR_W-1:0];
    assign grp_ext       = (STROBE_W + 1)'(scan_group_reg);
    assign strobe        = (grp_ext < (STROBE_W + 1)'(STROBE_W))
                         ? STROBE_W'({{(STROBE_W-1){1'b0}}, 1'b1} << grp_ext)
                         : '0;

    // Scan counter increments.
    assign grp_inc  = (GRP_W + 1)'(scan_group_reg) + 1'b1;
    assign lamp_inc = (LAMP_W + 1)'(scan_lamp_reg) + 1'b1;

    // Table memory: one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (ctrl.do_write && wr_in_range)
        begin
            lamp_mem[wr_addr] <= cmd_data.command_byte[MODE_W-1:0];
        end
        if (ctrl.do_scan)
        begin
            rd_mode_reg <= lamp_mem[rd_addr];
        end
    end

    // Scan capture of the fields that travel with the result.
    always_ff @(posedge clk)
    begin
        if (ctrl.do_scan)
        begin
            rd_hit_reg      <= entry_valid_reg[rd_addr];
            rd_in_range_reg <= scan_in_range;
            pend_data_reg   <= DATA_W'(scan_lamp_reg);
            pend_strobe_reg <= strobe;
        end
    end

    // Valid bits and fill mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fill_mode_reg   <= MODE_OFF;
        end
        else if (ctrl.do_fill)
        begin
            entry_valid_reg <= '0;
            fill_mode_reg   <= cmd_data.fill_mode;
        end
        else if (ctrl.do_write && wr_in_range)
        begin
            entry_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Scan counters: the group steps fastest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_lamp_reg  <= '0;
            scan_group_reg <= '0;
        end
        else if (ctrl.do_scan)
        begin
            if (grp_inc >= (GRP_W + 1)'(GROUP_COUNT))
            begin
                scan_group_reg <= '0;
                if (lamp_inc >= (LAMP_W + 1)'(LAMPS_PER_GROUP))
                begin
                    scan_lamp_reg <= '0;
                end
                else
                begin
                    scan_lamp_reg <= lamp_inc[LAMP_W-1:0];
                end
            end
            else
            begin
                scan_group_reg <= grp_inc[GRP_W-1:0];
            end
        end
    end

    // Blink phase and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_phase_reg <= '0;
            slow_on_reg     <= 1'b0;
            fast_on_reg     <= 1'b0;
        end
        else if (ctrl.do_blink)
        begin
            slow_on_reg     <= blink_phase_reg[1];
            fast_on_reg     <= blink_phase_reg[0];
            blink_phase_reg <= blink_phase_reg + 2'd1;
        end
    end

    // Lit decode from the read mode.
    assign cur_mode = rd_hit_reg ? rd_mode_reg : fill_mode_reg;

    always_comb
    begin
        unique case (cur_mode)
            MODE_ON:   lit = 1'b1;
            MODE_SLOW: lit = slow_on_reg;
            MODE_FAST: lit = fast_on_reg;
            default:   lit = 1'b0;
        endcase
        if (!rd_in_range_reg)
        begin
            lit = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_data_reg.lamp_data     <= pend_data_reg;
            out_data_reg.strobe_enable <= pend_strobe_reg;
            out_data_reg.lit           <= lit;
        end
    end

    assign status.out_free = !out_valid_reg || !res_stall;
    assign res_valid       = out_valid_reg;
    assign res_data        = out_data_reg;

endmodule

>>> src/lamp_matrix_scan_blink.sv
// Multiplexed lamp driver with per-lamp blink modes.
// Command channel (cmd_valid, cmd_stall, cmd_data): each transaction carries an
// operation: write one lamp, fill all lamps, scan tick or blink tick.
// Result channel (res_valid, res_stall, res_data): one transaction per scan tick,
// holding the lamp number in its group, the one-hot group strobe and the lit flag.
// Write, fill and blink transactions do not leave the idle state and produce no result.
// A scan tick reads the lamp table, a memory with a registered read port, as it is
// accepted; the mode is decoded in the lookup state that follows, and from there the
// result is loaded into the output register and appears on res_valid. Sustained rate
// is one command per cycle while idle; a scan holds off the next command in lookup.
// The output register lets the next command be taken while a result waits.
// If the receiver stalls, the result holds and a following scan waits in its
// lookup cycle, stalling the command channel until the output register frees.
// Reset clears every lamp to off through per-entry valid bits at once, and
// clears the scan counters and blink phase; no clearing pass is needed.
// A fill clears all the valid bits at once and records the fill mode.
module lamp_matrix_scan_blink #(
    parameter int LAMP_COUNT      = 64,
    parameter int GROUP_COUNT     = 4,
    parameter int LAMPS_PER_GROUP = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  lmsb_pkg::cmd_t  cmd_data,
    output logic            res_valid,
    input  logic            res_stall,
    output lmsb_pkg::res_t  res_data
);
    import lmsb_pkg::*;

    dp_ctrl_t   ctrl;
    dp_status_t status;

    lmsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .operation (cmd_data.operation),
        .cmd_stall (cmd_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    lmsb_datapath #(
        .LAMP_COUNT      (LAMP_COUNT),
        .GROUP_COUNT     (GROUP_COUNT),
        .LAMPS_PER_GROUP (LAMPS_PER_GROUP)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // An accepted scan holds off the next command for its lookup cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd_data.operation == OP_SCAN) |=> cmd_stall)
        else $error("scan accepted without a lookup cycle");

    // A command that is not a scan never creates a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd_data.operation != OP_SCAN && !res_valid)
        |=> !res_valid)
        else $error("result produced by a non-scan command");

    // A new result carries at most one strobe bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $onehot0(res_data.strobe_enable))
        else $error("strobe is not one-hot");

endmodule
